>>> hdl/lmqm_pkg.sv
// Package with command codes, queue kinds and shared types of the queue manager.
package lmqm_pkg;
   localparam logic [2:0] FUNC_APPEND      = 3'd0;
   localparam logic [2:0] FUNC_POP         = 3'd1;
   localparam logic [2:0] FUNC_UNLINK      = 3'd2;
   localparam logic [2:0] FUNC_POP_FREE    = 3'd3;
   localparam logic [2:0] FUNC_UNLINK_FREE = 3'd4;

   localparam logic [2:0] KIND_FREE    = 3'd0;
   localparam logic [2:0] KIND_SLICE   = 3'd1;
   localparam logic [2:0] KIND_BUFBLK  = 3'd2;
   localparam logic [2:0] KIND_DMA     = 3'd3;
   localparam logic [2:0] KIND_ROWBLK  = 3'd4;
   localparam logic [2:0] KIND_NAND    = 3'd5;
   localparam logic [2:0] KIND_NONE    = 3'd6;

   typedef struct packed {
      logic [2:0] func;
      logic [2:0] queue_kind;
      logic [6:0] slot_id;
      logic [2:0] channel;
      logic [2:0] way;
   } req_type;

   typedef struct packed {
      logic [6:0] slot_out;
      logic       empty_fail;
      logic [7:0] queue_len;
      logic [7:0] free_len;
      logic [7:0] blocked_total;
      logic [7:0] nand_pending;
   } rsp_type;
endpackage

>>> hdl/lmqm_if.sv
// Valid/ready channel interface carrying one payload item.
interface lmqm_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/linked_multi_queue_manager_top.sv
// Top level of the linked multi-queue manager.
// Each command holds the back-end sequencer until its result is taken on rsp: a refused
// command walks the read, decode and done states, an append adds the append step, a pop or
// unlink adds the next-slot and unlink steps, and one that returns the slot to the free
// queue adds a free-queue read and an append. Every step is one registered read of the link
// and queue tables followed by a write, and a two-entry command queue lets new commands be
// taken while one executes. After reset an init pass builds the free chain before work starts.
module linked_multi_queue_manager_top #(
   parameter int SLOTS = 128,
   parameter int CHANNELS = 8,
   parameter int WAYS = 8
) (
   input  logic clock,
   input  logic reset,
   lmqm_if.sink   req,
   lmqm_if.source rsp
);
   import lmqm_pkg::*;
   localparam int NQ = 4 + 2 * CHANNELS * WAYS;
   localparam int QW = $clog2(NQ);
   localparam int SW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);

   logic cv, cr, cok;
   logic [QW-1:0] cq;
   logic [2:0] cf;
   logic [6:0] cs;
   rsp_type r;

   lmqm_front #(.CHANNELS(CHANNELS), .WAYS(WAYS), .QW(QW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_req(req.payload),
      .out_valid(cv), .out_ready(cr), .out_ok(cok), .out_q(cq),
      .out_func(cf), .out_slot(cs)
   );

   lmqm_back #(.SLOTS(SLOTS), .NQ(NQ), .QW(QW), .SW(SW), .LW(LW)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cv), .cmd_ready(cr), .cmd_ok(cok), .cmd_q(cq),
      .cmd_func(cf), .cmd_slot(cs),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r)
   );
   assign rsp.payload = r;
endmodule

>>> hdl/lmqm_front.sv
// Front end: accepts commands, classifies them and pushes them into a short queue.
module lmqm_front #(
   parameter int CHANNELS = 8,
   parameter int WAYS = 8,
   parameter int QW = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lmqm_pkg::req_type   in_req,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_ok,
   output logic [QW-1:0]       out_q,
   output logic [2:0]          out_func,
   output logic [6:0]          out_slot
);
   import lmqm_pkg::*;
   localparam int DIES = CHANNELS * WAYS;
   localparam int DEPTH = 2;
   localparam int ENTRY_W = 1 + QW + 3 + 7;

   logic [ENTRY_W-1:0] fifo_ff [DEPTH];
   logic [ENTRY_W-1:0] fifo_in [DEPTH];
   logic [1:0] count_ff, count_in;
   logic ok;
   logic [QW-1:0] q;
   logic push, pop;

   always_comb begin
      ok = 1'b0;
      q = '0;
      if (in_req.queue_kind < KIND_ROWBLK) begin
         ok = 1'b1;
         q = QW'(in_req.queue_kind);
      end else if ((in_req.queue_kind == KIND_ROWBLK || in_req.queue_kind == KIND_NAND)
                   && 32'(in_req.channel) < CHANNELS && 32'(in_req.way) < WAYS) begin
         ok = 1'b1;
         q = QW'(4 + ((in_req.queue_kind == KIND_NAND) ? DIES : 0)
                 + 32'(in_req.channel) * WAYS + 32'(in_req.way));
      end
   end

   assign in_ready = (count_ff != 2'(DEPTH));
   assign push = in_valid && in_ready;
   assign out_valid = (count_ff != 2'd0);
   assign pop = out_valid && out_ready;
   assign {out_ok, out_q, out_func, out_slot} = fifo_ff[0];

   always_comb begin
      fifo_in = fifo_ff;
      count_in = count_ff;
      if (pop) begin
         fifo_in[0] = fifo_ff[1];
         count_in = count_in - 2'd1;
      end
      if (push) begin
         fifo_in[count_in[0]] = {ok, q, in_req.func, in_req.slot_id};
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

>>> hdl/lmqm_back.sv
// Back end: sequencer that walks the link and queue memories for one command.
module lmqm_back #(
   parameter int SLOTS = 128,
   parameter int NQ = 132,
   parameter int QW = 8,
   parameter int SW = 7,
   parameter int LW = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  logic                cmd_ok,
   input  logic [QW-1:0]       cmd_q,
   input  logic [2:0]          cmd_func,
   input  logic [6:0]          cmd_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lmqm_pkg::rsp_type   rsp
);
   import lmqm_pkg::*;
   localparam logic [LW-1:0] NONE = LW'(SLOTS);
   localparam int DIES = (NQ - 4) / 2;

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RD    = 4'd2;
   localparam logic [3:0] ST_DEC   = 4'd3;
   localparam logic [3:0] ST_NB    = 4'd4;
   localparam logic [3:0] ST_UN    = 4'd5;
   localparam logic [3:0] ST_FRD   = 4'd6;
   localparam logic [3:0] ST_AP    = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;
   localparam logic [3:0] ST_RSP   = 4'd9;

   logic [LW-1:0] prev_mem [SLOTS];
   logic [LW-1:0] next_mem [SLOTS];
   logic [2:0]    owner_mem [SLOTS];
   logic [QW-1:0] sq_mem [SLOTS];
   logic [LW-1:0] head_mem [NQ];
   logic [LW-1:0] tail_mem [NQ];
   logic [LW-1:0] cnt_mem [NQ];

   logic [3:0] state_ff, state_in;
   logic [LW-1:0] init_ff;
   logic [QW-1:0] q_ff, aq_ff;
   logic [2:0] func_ff;
   logic [LW-1:0] s_ff;
   logic ok_ff, fail_ff, tofree_ff;
   logic [LW-1:0] head_rd, tail_rd, cnt_rd;
   logic [LW-1:0] prev_rd, next_rd;
   logic [2:0] owner_rd;
   logic [QW-1:0] sq_rd;
   logic [LW-1:0] blk_ff, nand_ff;
   logic [LW-1:0] free_cnt_ff;
   logic [LW-1:0] cnt_mem_q;
   logic [6:0] sout_ff;
   logic rsp_valid_ff;

   function automatic logic [2:0] kind_of(input logic [QW-1:0] qq);
      logic [2:0] k;
      if (32'(qq) < 4) k = qq[2:0];
      else if (32'(qq) < 4 + DIES) k = KIND_ROWBLK;
      else k = KIND_NAND;
      return k;
   endfunction

   function automatic logic [LW-1:0] sum_adj(input logic [LW-1:0] v, input logic hit,
                                             input logic up);
      logic [LW-1:0] r;
      r = v;
      if (hit) r = up ? v + 1'b1 : v - 1'b1;
      return r;
   endfunction

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp.slot_out = sout_ff;
   assign rsp.empty_fail = fail_ff;
   assign rsp.queue_len = ok_ff ? 8'(cnt_mem_q) : 8'd0;
   assign rsp.free_len = 8'(free_cnt_ff);
   assign rsp.blocked_total = 8'(blk_ff);
   assign rsp.nand_pending = 8'(nand_ff);

   logic [2:0] ak;
   assign ak = kind_of(aq_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: if (32'(init_ff) >= ((NQ > SLOTS) ? NQ : SLOTS) - 1) state_in = ST_IDLE;
         ST_IDLE: if (cmd_valid) state_in = ST_RD;
         ST_RD: state_in = ST_DEC;
         ST_DEC: begin
            if (!ok_ff) begin
               state_in = ST_DONE;
            end else if (func_ff == FUNC_APPEND) begin
               state_in = (32'(s_ff) < SLOTS && owner_rd == KIND_NONE) ? ST_AP : ST_DONE;
            end else if (func_ff == FUNC_POP || func_ff == FUNC_POP_FREE) begin
               state_in = (cnt_rd != '0 && 32'(head_rd) < SLOTS) ? ST_NB : ST_DONE;
            end else if (func_ff == FUNC_UNLINK || func_ff == FUNC_UNLINK_FREE) begin
               state_in = (32'(s_ff) < SLOTS && owner_rd != KIND_NONE && sq_rd == q_ff)
                          ? ST_NB : ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_NB: state_in = ST_UN;
         ST_UN: state_in = tofree_ff ? ST_FRD : ST_DONE;
         ST_FRD: state_in = ST_AP;
         ST_AP: state_in = ST_DONE;
         ST_DONE: state_in = ST_RSP;
         ST_RSP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // Memory reads, registered.
      head_rd <= head_mem[aq_ff];
      tail_rd <= tail_mem[aq_ff];
      cnt_rd <= cnt_mem[aq_ff];
      prev_rd <= prev_mem[s_ff[SW-1:0]];
      next_rd <= next_mem[s_ff[SW-1:0]];
      owner_rd <= owner_mem[s_ff[SW-1:0]];
      sq_rd <= sq_mem[s_ff[SW-1:0]];
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff <= '0;
         blk_ff <= '0;
         nand_ff <= '0;
         rsp_valid_ff <= 1'b0;
         free_cnt_ff <= LW'(SLOTS);
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == ST_RSP && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               if (32'(init_ff) < SLOTS) begin
                  prev_mem[init_ff[SW-1:0]] <= (init_ff == '0) ? NONE : init_ff - 1'b1;
                  next_mem[init_ff[SW-1:0]] <= init_ff + 1'b1;
                  owner_mem[init_ff[SW-1:0]] <= KIND_FREE;
                  sq_mem[init_ff[SW-1:0]] <= '0;
               end
               if (32'(init_ff) < NQ) begin
                  head_mem[QW'(init_ff)] <= (init_ff == '0) ? '0 : NONE;
                  tail_mem[QW'(init_ff)] <= (init_ff == '0) ? LW'(SLOTS - 1) : NONE;
                  cnt_mem[QW'(init_ff)] <= (init_ff == '0) ? LW'(SLOTS) : '0;
               end
               init_ff <= init_ff + 1'b1;
            end
            ST_IDLE: begin
               q_ff <= cmd_q;
               aq_ff <= cmd_q;
               func_ff <= cmd_func;
               s_ff <= LW'(cmd_slot);
               ok_ff <= cmd_ok;
               tofree_ff <= (cmd_func == FUNC_POP_FREE || cmd_func == FUNC_UNLINK_FREE);
               fail_ff <= 1'b1;
               sout_ff <= '0;
            end
            ST_DEC: begin
               if (func_ff == FUNC_POP || func_ff == FUNC_POP_FREE) s_ff <= head_rd;
            end
            ST_NB: begin
               // Slot address now valid; the registered prev/next reads are used in ST_UN.
               fail_ff <= 1'b0;
               sout_ff <= s_ff[6:0];
            end
            ST_UN: begin
               if (32'(prev_rd) < SLOTS) next_mem[prev_rd[SW-1:0]] <= next_rd;
               else head_mem[aq_ff] <= next_rd;
               if (32'(next_rd) < SLOTS) prev_mem[next_rd[SW-1:0]] <= prev_rd;
               else tail_mem[aq_ff] <= prev_rd;
               owner_mem[s_ff[SW-1:0]] <= KIND_NONE;
               if (cnt_rd != '0) cnt_mem[aq_ff] <= cnt_rd - 1'b1;
               if (aq_ff == '0 && cnt_rd != '0) free_cnt_ff <= cnt_rd - 1'b1;
               blk_ff <= sum_adj(blk_ff, ak == KIND_BUFBLK || ak == KIND_ROWBLK, 1'b0);
               nand_ff <= sum_adj(nand_ff, ak == KIND_NAND, 1'b0);
               aq_ff <= '0;
            end
            ST_AP: begin
               next_mem[s_ff[SW-1:0]] <= NONE;
               if (32'(tail_rd) < SLOTS) begin
                  prev_mem[s_ff[SW-1:0]] <= tail_rd;
                  next_mem[tail_rd[SW-1:0]] <= s_ff;
               end else begin
                  prev_mem[s_ff[SW-1:0]] <= NONE;
                  head_mem[aq_ff] <= s_ff;
               end
               tail_mem[aq_ff] <= s_ff;
               owner_mem[s_ff[SW-1:0]] <= ak;
               sq_mem[s_ff[SW-1:0]] <= aq_ff;
               cnt_mem[aq_ff] <= cnt_rd + 1'b1;
               if (aq_ff == '0) free_cnt_ff <= cnt_rd + 1'b1;
               blk_ff <= sum_adj(blk_ff, ak == KIND_BUFBLK || ak == KIND_ROWBLK, 1'b1);
               nand_ff <= sum_adj(nand_ff, ak == KIND_NAND, 1'b1);
               fail_ff <= 1'b0;
               sout_ff <= s_ff[6:0];
               aq_ff <= q_ff;
            end
            ST_DONE: begin
               aq_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Count of the addressed queue, registered from the table every cycle for the response.
   always_ff @(posedge clock) begin
      cnt_mem_q <= cnt_mem[q_ff];
   end
endmodule

>>> dv/tb.sv
// Self-checking testbench for the linked multi-queue manager: directed and random commands.
`timescale 1ns / 100ps
module tb;
   import lmqm_pkg::*;

   localparam int SLOTS = 128;
   localparam int CHANNELS = 8;
   localparam int WAYS = 8;
   localparam int DIES = CHANNELS * WAYS;
   localparam int NQ = 4 + 2 * DIES;
   localparam int LINK_NONE = SLOTS;

   logic clock;
   logic reset;
   lmqm_if #(.payload_type(req_type)) req (clock);
   lmqm_if #(.payload_type(rsp_type)) rsp (clock);

   linked_multi_queue_manager_top #(.SLOTS(SLOTS), .CHANNELS(CHANNELS), .WAYS(WAYS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   int prev_slot[SLOTS];
   int next_slot[SLOTS];
   logic [2:0] owner_kind[SLOTS];
   int owner_queue[SLOTS];
   int head_of[NQ];
   int tail_of[NQ];
   int count_of[NQ];
   int blocked_count;
   int nand_count;
   rsp_type expected_rsps[$];
   int error_count;
   bit rsp_busy;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [2:0] kind_of_queue(int q);
      if (q < 4) begin
         return q[2:0];
      end
      return (q < 4 + DIES) ? KIND_ROWBLK : KIND_NAND;
   endfunction

   function automatic void bump_totals(logic [2:0] kind, int delta);
      if (kind == KIND_BUFBLK || kind == KIND_ROWBLK) begin
         blocked_count += delta;
      end
      if (kind == KIND_NAND) begin
         nand_count += delta;
      end
   endfunction

   function automatic void link_at_tail(int q, int s);
      int t;
      t = tail_of[q];
      next_slot[s] = LINK_NONE;
      if (t < SLOTS) begin
         prev_slot[s] = t;
         next_slot[t] = s;
      end else begin
         prev_slot[s] = LINK_NONE;
         head_of[q] = s;
      end
      tail_of[q] = s;
      owner_kind[s] = kind_of_queue(q);
      owner_queue[s] = q;
      count_of[q]++;
      bump_totals(kind_of_queue(q), 1);
   endfunction

   function automatic void take_out(int q, int s);
      int p;
      int n;
      p = prev_slot[s];
      n = next_slot[s];
      if (p < SLOTS) begin
         next_slot[p] = n;
      end else begin
         head_of[q] = n;
      end
      if (n < SLOTS) begin
         prev_slot[n] = p;
      end else begin
         tail_of[q] = p;
      end
      owner_kind[s] = KIND_NONE;
      if (count_of[q] != 0) begin
         count_of[q]--;
      end
      bump_totals(kind_of_queue(q), -1);
   endfunction

   function automatic void clear_queues();
      for (int i = 0; i < SLOTS; i++) begin
         prev_slot[i] = (i == 0) ? LINK_NONE : i - 1;
         next_slot[i] = i + 1;
         owner_kind[i] = KIND_FREE;
         owner_queue[i] = 0;
      end
      for (int i = 0; i < NQ; i++) begin
         head_of[i] = LINK_NONE;
         tail_of[i] = LINK_NONE;
         count_of[i] = 0;
      end
      head_of[0] = 0;
      tail_of[0] = SLOTS - 1;
      count_of[0] = SLOTS;
      blocked_count = 0;
      nand_count = 0;
   endfunction

   function automatic rsp_type apply_command(req_type c);
      rsp_type r;
      bit addr_ok;
      int q;
      int s;
      addr_ok = 1'b0;
      q = 0;
      r = '0;
      r.empty_fail = 1'b1;
      if (c.queue_kind < KIND_ROWBLK) begin
         addr_ok = 1'b1;
         q = int'(c.queue_kind);
      end else if (c.queue_kind <= KIND_NAND && c.channel < CHANNELS && c.way < WAYS) begin
         addr_ok = 1'b1;
         q = 4 + (c.queue_kind == KIND_NAND ? DIES : 0) + int'(c.channel) * WAYS
             + int'(c.way);
      end
      if (addr_ok) begin
         if (c.func == FUNC_APPEND) begin
            if (owner_kind[c.slot_id] == KIND_NONE) begin
               link_at_tail(q, int'(c.slot_id));
               r.slot_out = c.slot_id;
               r.empty_fail = 1'b0;
            end
         end else if (c.func == FUNC_POP || c.func == FUNC_POP_FREE) begin
            s = head_of[q];
            if (count_of[q] != 0 && s < SLOTS) begin
               take_out(q, s);
               if (c.func == FUNC_POP_FREE) begin
                  link_at_tail(0, s);
               end
               r.slot_out = s[6:0];
               r.empty_fail = 1'b0;
            end
         end else if (c.func == FUNC_UNLINK || c.func == FUNC_UNLINK_FREE) begin
            if (owner_kind[c.slot_id] != KIND_NONE && owner_queue[c.slot_id] == q) begin
               take_out(q, int'(c.slot_id));
               if (c.func == FUNC_UNLINK_FREE) begin
                  link_at_tail(0, int'(c.slot_id));
               end
               r.slot_out = c.slot_id;
               r.empty_fail = 1'b0;
            end
         end
      end
      r.queue_len = addr_ok ? count_of[q][7:0] : 8'd0;
      r.free_len = count_of[0][7:0];
      r.blocked_total = blocked_count[7:0];
      r.nand_pending = nand_count[7:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_command(req_type c);
      req.valid <= 1'b1;
      req.payload <= c;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      expected_rsps.push_back(apply_command(c));
      if (rsp_busy) begin
         repeat (pick_gap()) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic send_fields(logic [2:0] f, logic [2:0] k, logic [6:0] s,
                              logic [2:0] ch, logic [2:0] w);
      req_type c;
      c.func = f;
      c.queue_kind = k;
      c.slot_id = s;
      c.channel = ch;
      c.way = w;
      send_command(c);
   endtask

   task automatic drain_results();
      while (expected_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected item: %p", rsp.payload);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp.payload.slot_out !== want.slot_out) begin
               $error("slot_out exp %0d got %0d", want.slot_out, rsp.payload.slot_out);
               error_count++;
            end
            if (rsp.payload.empty_fail !== want.empty_fail) begin
               $error("empty_fail exp %0d got %0d", want.empty_fail, rsp.payload.empty_fail);
               error_count++;
            end
            if (rsp.payload.queue_len !== want.queue_len) begin
               $error("queue_len exp %0d got %0d", want.queue_len, rsp.payload.queue_len);
               error_count++;
            end
            if (rsp.payload.free_len !== want.free_len) begin
               $error("free_len exp %0d got %0d", want.free_len, rsp.payload.free_len);
               error_count++;
            end
            if (rsp.payload.blocked_total !== want.blocked_total) begin
               $error("blocked_total exp %0d got %0d", want.blocked_total,
                      rsp.payload.blocked_total);
               error_count++;
            end
            if (rsp.payload.nand_pending !== want.nand_pending) begin
               $error("nand_pending exp %0d got %0d", want.nand_pending,
                      rsp.payload.nand_pending);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !rsp_busy) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 :
                      1'b1) & ($urandom_range(0, 2) != 0);
      end
   end

   task automatic test_directed();
      send_fields(FUNC_POP, KIND_SLICE, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_POP, KIND_FREE, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_SLICE, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_SLICE, 7'd5, 3'd0, 3'd0);
      send_fields(FUNC_UNLINK, KIND_FREE, 7'd127, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_NAND, 7'd127, 3'd7, 3'd7);
      send_fields(FUNC_UNLINK, KIND_FREE, 7'd64, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_ROWBLK, 7'd64, 3'd7, 3'd0);
      send_fields(FUNC_POP_FREE, KIND_FREE, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_UNLINK, KIND_FREE, 7'd1, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_BUFBLK, 7'd1, 3'd0, 3'd0);
      send_fields(FUNC_UNLINK, KIND_FREE, 7'd2, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, KIND_DMA, 7'd2, 3'd5, 3'd6);
      send_fields(FUNC_UNLINK, KIND_ROWBLK, 7'd64, 3'd0, 3'd7);
      send_fields(FUNC_UNLINK_FREE, KIND_ROWBLK, 7'd64, 3'd7, 3'd0);
      send_fields(FUNC_UNLINK_FREE, KIND_NAND, 7'd127, 3'd7, 3'd7);
      send_fields(FUNC_POP_FREE, KIND_BUFBLK, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_POP, KIND_DMA, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_POP_FREE, KIND_NAND, 7'd0, 3'd0, 3'd0);
      send_fields(3'd5, KIND_FREE, 7'd3, 3'd0, 3'd0);
      send_fields(3'd7, KIND_SLICE, 7'd3, 3'd0, 3'd0);
      send_fields(FUNC_POP, 3'd6, 7'd0, 3'd0, 3'd0);
      send_fields(FUNC_APPEND, 3'd7, 7'd2, 3'd0, 3'd0);
      send_fields(FUNC_POP_FREE, KIND_SLICE, 7'd0, 3'd0, 3'd0);
   endtask

   task automatic test_random(int n_items);
      req_type c;
      int s;
      int roll;
      for (int i = 0; i < n_items; i++) begin
         c.func = 3'($urandom_range(0, 4));
         c.queue_kind = 3'($urandom_range(0, 5));
         c.channel = 3'($urandom_range(0, 7));
         c.way = 3'($urandom_range(0, 7));
         c.slot_id = 7'($urandom_range(0, SLOTS - 1));
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            c = req_type'($urandom());
         end else if (c.func == FUNC_APPEND && roll < 80) begin
            for (int k = 0; k < 8; k++) begin
               s = $urandom_range(0, SLOTS - 1);
               if (owner_kind[s] == KIND_NONE) begin
                  c.slot_id = 7'(s);
               end
            end
         end else if ((c.func == FUNC_UNLINK || c.func == FUNC_UNLINK_FREE) && roll < 80) begin
            s = $urandom_range(0, SLOTS - 1);
            if (owner_kind[s] != KIND_NONE && owner_queue[s] != 0) begin
               c.slot_id = 7'(s);
               c.queue_kind = owner_kind[s];
               if (owner_queue[s] >= 4) begin
                  c.channel = 3'(((owner_queue[s] - 4) % DIES) / WAYS);
                  c.way = 3'((owner_queue[s] - 4) % WAYS);
               end
            end else if (c.queue_kind == KIND_FREE || roll < 60) begin
               c.slot_id = head_of[0] < SLOTS ? 7'(head_of[0]) : c.slot_id;
               c.queue_kind = KIND_FREE;
            end
         end else if (roll < 30) begin
            c.channel = 3'($urandom_range(0, 1));
            c.way = 3'($urandom_range(0, 1));
         end
         send_command(c);
         if (i == n_items / 2) begin
            req.valid <= 1'b0;
            drain_results();
         end
      end
   endtask

   initial begin
      error_count = 0;
      rsp_busy = 1'b0;
      clear_queues();
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      rsp_busy = 1'b1;
      test_random(2000);
      req.valid <= 1'b0;
      drain_results();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
